/* hdl/sfs_pkg.sv */
package sfs_pkg;

   localparam int NUM_ANIMS_DEF  = 16;
   localparam int MAX_FRAMES_DEF = 16;

   localparam int SEL_W     = 4;
   localparam int SPRITE_W  = 16;
   localparam int TIME_W    = 24;
   localparam int ELAPSED_W = 25;
   localparam int PLAYED_W  = 28;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [PLAYED_W-1:0]  PLAYED_MAX  = '1;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CREATE = 3'd1,
      OP_APPEND = 3'd2,
      OP_PLAY   = 3'd3,
      OP_STOP   = 3'd4,
      OP_PAUSE  = 3'd5,
      OP_RESUME = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [SPRITE_W-1:0] sprite;
      logic [TIME_W-1:0]   duration;
   } frame_type;

endpackage

/* hdl/sprite_frame_sequencer.sv */
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+----------------------------------
// request  | req_op, req_anim_sel, req_sprite_num,   | taken when start && !busy
//          | req_time_value, req_loop_flag           |
// response | rsp_cur_sprite, rsp_playing_now,        | rsp_valid strobe, one cycle,
//          | rsp_done_flag, rsp_played_time,         | always taken
//          | rsp_error_flag                          |
//
// Every transaction but a tick that walks frames passes from S_EXEC straight to S_RESP after the accept edge.
// A tick walks one frame per cycle through the frame memory, at most one pass of its frames;
// the single read port of the frame memory sets that rate.
// busy stays high from the accept edge through the response cycle.
// Synchronous active-high reset clears all animations; no clearing pass is needed.
// The receiver cannot stall: the response is presented for exactly one cycle.
module sprite_frame_sequencer #(
   parameter int NUM_ANIMS  = sfs_pkg::NUM_ANIMS_DEF,
   parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_op,
   input  logic [sfs_pkg::SEL_W-1:0]     req_anim_sel,
   input  logic [sfs_pkg::SPRITE_W-1:0]  req_sprite_num,
   input  logic [sfs_pkg::TIME_W-1:0]    req_time_value,
   input  logic                          req_loop_flag,
   output logic                          rsp_valid,
   output logic [sfs_pkg::SPRITE_W-1:0]  rsp_cur_sprite,
   output logic                          rsp_playing_now,
   output logic                          rsp_done_flag,
   output logic [sfs_pkg::PLAYED_W-1:0]  rsp_played_time,
   output logic                          rsp_error_flag
);

   localparam int AIW   = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
   localparam int PW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int LW    = $clog2(MAX_FRAMES + 1);
   localparam int DEPTH = NUM_ANIMS * MAX_FRAMES;
   localparam int FAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SXW   = AIW + sfs_pkg::SEL_W;

   sfs_pkg::state_type state_ff, state_in;
   sfs_pkg::op_type    op_ff;
   logic [sfs_pkg::SEL_W-1:0]     sel_ff;
   logic [sfs_pkg::SPRITE_W-1:0]  spr_ff;
   logic [sfs_pkg::TIME_W-1:0]    tv_ff;
   logic                          lp_ff;

   logic [NUM_ANIMS-1:0]           exists_ff, exists_in;
   logic [AIW-1:0]                 active_ff, active_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [LW-1:0]                  act_len_ff, act_len_in;
   logic                           act_ok_ff, act_ok_in;
   logic [LW-1:0]                  n_ff, n_in;
   logic [sfs_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [sfs_pkg::PLAYED_W-1:0]   played_ff, played_in;
   logic                           playing_ff, playing_in;
   logic                           looping_ff, looping_in;
   logic                           done_ff, done_in;
   logic                           err_ff, err_in;

   logic [LW-1:0]        len_mem [NUM_ANIMS];
   sfs_pkg::frame_type   frame_mem [DEPTH];
   logic [LW-1:0]        len_rd_ff;
   sfs_pkg::frame_type   frame_rd_ff;

   logic                 len_we;
   logic [LW-1:0]        len_wdata;
   logic [AIW-1:0]       len_raddr;
   logic                 frame_we;
   logic [FAW-1:0]       frame_waddr;
   logic [FAW-1:0]       frame_raddr;
   sfs_pkg::frame_type   frame_wdata;

   logic [SXW-1:0]       sel_ext;
   logic [AIW-1:0]       sel_idx;
   logic                 sel_in_range;
   logic                 sel_ok;
   logic                 usable;
   logic [LW-1:0]        pos_plus;
   logic                 wrap;
   logic [sfs_pkg::TIME_W-1:0]      dur;
   logic [sfs_pkg::ELAPSED_W:0]     elapsed_sum;
   logic [sfs_pkg::PLAYED_W:0]      played_sum;

   assign len_raddr    = AIW'(req_anim_sel);
   assign sel_ext      = SXW'(sel_ff);
   assign sel_idx      = sel_ext[AIW-1:0];
   assign sel_in_range = sel_ext < SXW'(NUM_ANIMS);
   assign sel_ok       = sel_in_range && exists_ff[sel_idx];
   assign usable       = act_ok_ff && (act_len_ff != '0) && (LW'(pos_ff) < act_len_ff);
   assign pos_plus     = LW'(pos_ff) + LW'(1);
   assign wrap         = pos_plus >= act_len_ff;
   assign dur          = frame_rd_ff.duration;
   assign elapsed_sum  = (sfs_pkg::ELAPSED_W + 1)'(elapsed_ff) +
                         (sfs_pkg::ELAPSED_W + 1)'(tv_ff);
   assign played_sum   = (sfs_pkg::PLAYED_W + 1)'(played_ff) +
                         (sfs_pkg::PLAYED_W + 1)'(dur);

   assign frame_wdata  = '{sprite: spr_ff, duration: tv_ff};
   assign frame_waddr  = FAW'(32'(sel_idx) * 32'(MAX_FRAMES) + 32'(len_rd_ff));
   assign len_wdata    = (op_ff == sfs_pkg::OP_CREATE) ? '0 : len_rd_ff + LW'(1);

   // read at the next-state frame so the current sprite is registered alongside the new state
   assign frame_raddr  = FAW'(32'(active_in) * 32'(MAX_FRAMES) + 32'(pos_in));

   always_comb begin
      state_in   = state_ff;
      exists_in  = exists_ff;
      active_in  = active_ff;
      pos_in     = pos_ff;
      act_len_in = act_len_ff;
      act_ok_in  = act_ok_ff;
      n_in       = n_ff;
      elapsed_in = elapsed_ff;
      played_in  = played_ff;
      playing_in = playing_ff;
      looping_in = looping_ff;
      done_in    = done_ff;
      err_in     = err_ff;
      len_we     = 1'b0;
      frame_we   = 1'b0;
      case (state_ff)
         sfs_pkg::S_IDLE: begin
            if (start) begin
               state_in = sfs_pkg::S_EXEC;
            end
         end
         sfs_pkg::S_EXEC: begin
            err_in   = 1'b0;
            state_in = sfs_pkg::S_RESP;
            case (op_ff)
               sfs_pkg::OP_TICK: begin
                  if (playing_ff) begin
                     if (!usable) begin
                        err_in = 1'b1;
                     end else begin
                        elapsed_in = elapsed_sum[sfs_pkg::ELAPSED_W] ? sfs_pkg::ELAPSED_MAX
                                     : elapsed_sum[sfs_pkg::ELAPSED_W-1:0];
                        n_in       = '0;
                        state_in   = sfs_pkg::S_WALK;
                     end
                  end
               end
               sfs_pkg::OP_CREATE: begin
                  if (!sel_in_range || exists_ff[sel_idx]) begin
                     err_in = 1'b1;
                  end else begin
                     exists_in[sel_idx] = 1'b1;
                     len_we             = 1'b1;
                     if (sel_idx == active_ff) begin
                        act_ok_in  = 1'b1;
                        act_len_in = '0;
                     end
                  end
               end
               sfs_pkg::OP_APPEND: begin
                  if (!sel_ok || len_rd_ff >= LW'(MAX_FRAMES)) begin
                     err_in = 1'b1;
                  end else begin
                     len_we   = 1'b1;
                     frame_we = 1'b1;
                     if (sel_idx == active_ff) begin
                        act_len_in = len_rd_ff + LW'(1);
                     end
                  end
               end
               sfs_pkg::OP_PLAY: begin
                  if (!sel_ok || len_rd_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     playing_in = 1'b1;
                     looping_in = lp_ff;
                     done_in    = 1'b0;
                     active_in  = sel_idx;
                     act_ok_in  = 1'b1;
                     act_len_in = len_rd_ff;
                     pos_in     = '0;
                     elapsed_in = sfs_pkg::ELAPSED_W'(tv_ff);
                     played_in  = '0;
                  end
               end
               sfs_pkg::OP_STOP: begin
                  playing_in = 1'b0;
                  looping_in = 1'b0;
                  done_in    = 1'b1;
                  pos_in     = '0;
                  elapsed_in = '0;
                  played_in  = '0;
               end
               sfs_pkg::OP_PAUSE: begin
                  playing_in = 1'b0;
               end
               sfs_pkg::OP_RESUME: begin
                  playing_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         sfs_pkg::S_WALK: begin
            if (n_ff >= act_len_ff ||
                elapsed_ff < sfs_pkg::ELAPSED_W'(dur)) begin
               state_in = sfs_pkg::S_RESP;
            end else begin
               elapsed_in = elapsed_ff - sfs_pkg::ELAPSED_W'(dur);
               played_in  = played_sum[sfs_pkg::PLAYED_W] ? sfs_pkg::PLAYED_MAX
                            : played_sum[sfs_pkg::PLAYED_W-1:0];
               pos_in     = pos_plus[PW-1:0];
               n_in       = n_ff + LW'(1);
               if (wrap) begin
                  pos_in    = '0;
                  played_in = '0;
                  if (!looping_ff) begin
                     done_in    = 1'b1;
                     playing_in = 1'b0;
                     state_in   = sfs_pkg::S_RESP;
                  end
               end
            end
         end
         sfs_pkg::S_RESP: begin
            state_in = sfs_pkg::S_IDLE;
         end
         default: begin
            state_in = sfs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sfs_pkg::S_IDLE;
         exists_ff  <= '0;
         active_ff  <= '0;
         pos_ff     <= '0;
         act_len_ff <= '0;
         act_ok_ff  <= 1'b0;
         n_ff       <= '0;
         elapsed_ff <= '0;
         played_ff  <= '0;
         playing_ff <= 1'b0;
         looping_ff <= 1'b0;
         done_ff    <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         exists_ff  <= exists_in;
         active_ff  <= active_in;
         pos_ff     <= pos_in;
         act_len_ff <= act_len_in;
         act_ok_ff  <= act_ok_in;
         n_ff       <= n_in;
         elapsed_ff <= elapsed_in;
         played_ff  <= played_in;
         playing_ff <= playing_in;
         looping_ff <= looping_in;
         done_ff    <= done_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sfs_pkg::S_IDLE && start) begin
         op_ff  <= sfs_pkg::op_type'(req_op);
         sel_ff <= req_anim_sel;
         spr_ff <= req_sprite_num;
         tv_ff  <= req_time_value;
         lp_ff  <= req_loop_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[sel_idx] <= len_wdata;
      end
      len_rd_ff <= len_mem[len_raddr];
   end

   // forward a frame written to the entry being read
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      if (frame_we && frame_waddr == frame_raddr) begin
         frame_rd_ff <= frame_wdata;
      end else begin
         frame_rd_ff <= frame_mem[frame_raddr];
      end
   end

   assign busy            = state_ff != sfs_pkg::S_IDLE;
   assign rsp_valid       = state_ff == sfs_pkg::S_RESP;
   assign rsp_cur_sprite  = usable ? frame_rd_ff.sprite : '0;
   assign rsp_playing_now = playing_ff;
   assign rsp_done_flag   = done_ff;
   assign rsp_played_time = played_ff;
   assign rsp_error_flag  = err_ff;

   a_resp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transaction did not raise busy");

   a_walk_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == sfs_pkg::S_WALK |-> n_ff <= act_len_ff)
      else $error("frame walk ran past one pass of the table");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      act_ok_ff |-> act_len_ff == '0 || LW'(pos_ff) < act_len_ff)
      else $error("frame position beyond animation length");

endmodule
